// ----- sv/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg
// shared constants and the arctangent table for the euler to quaternion block
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int VEC_BITS = 33;
  localparam int ATAN_BITS = 32;
  localparam int MAX_STEPS = 32;
  localparam logic signed [VEC_BITS-1:0] GAIN_Q30 = 33'sd652032874;

  function automatic logic signed [ATAN_BITS:0] atan_entry(input int idx);
    logic signed [ATAN_BITS:0] v;
    begin
      unique case (idx)
        0: v = 33'sd536870912;
        1: v = 33'sd316933406;
        2: v = 33'sd167458907;
        3: v = 33'sd85004756;
        4: v = 33'sd42667331;
        5: v = 33'sd21354465;
        6: v = 33'sd10679838;
        7: v = 33'sd5340245;
        8: v = 33'sd2670163;
        9: v = 33'sd1335087;
        10: v = 33'sd667544;
        11: v = 33'sd333772;
        12: v = 33'sd166886;
        13: v = 33'sd83443;
        14: v = 33'sd41722;
        15: v = 33'sd20861;
        16: v = 33'sd10430;
        17: v = 33'sd5215;
        18: v = 33'sd2608;
        19: v = 33'sd1304;
        20: v = 33'sd652;
        21: v = 33'sd326;
        22: v = 33'sd163;
        23: v = 33'sd81;
        24: v = 33'sd41;
        25: v = 33'sd20;
        26: v = 33'sd10;
        27: v = 33'sd5;
        28: v = 33'sd3;
        29: v = 33'sd1;
        30: v = 33'sd1;
        default: v = 33'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- sv/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// zyx euler angles to unit quaternion: three cordic lanes and a product merge
//
// channel  signals                                    dir
// in       in_valid in_ready roll/pitch/yaw_angle     in
// out      out_valid out_ready quat_w/x/y/z           out
//
// one item per cycle unless stalled; the data passes the cordic stages plus
// five merge stages. the whole pipeline advances together and holds when the
// output register is full and not taken. reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [FRAC_BITS+1:0] quat_w,
  output logic signed [FRAC_BITS+1:0] quat_x,
  output logic signed [FRAC_BITS+1:0] quat_y,
  output logic signed [FRAC_BITS+1:0] quat_z
);
  import e2q_pkg::*;

  localparam int LAT = CORDIC_STEPS + 6;

  logic en;
  logic [LAT-1:0] vld;
  logic signed [VEC_BITS-1:0] cr, sr, cp, sp, cy, sy;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .angle(roll_angle), .cos_out(cr), .sin_out(sr));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .cos_out(cp), .sin_out(sp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .cos_out(cy), .sin_out(sy));

  e2q_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z));

endmodule

// ----- sv/e2q_cordic.sv -----
// ----------------------------------------------------------------------------
// e2q_cordic
// pipelined rotation cordic, one step per stage, gives cos and sin of a
// half angle in q30
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [e2q_pkg::VEC_BITS-1:0] cos_out,
  output logic signed [e2q_pkg::VEC_BITS-1:0] sin_out
);
  import e2q_pkg::*;

  localparam int ZB = ATAN_BITS + 1;

  logic signed [VEC_BITS-1:0] xs [CORDIC_STEPS+1];
  logic signed [VEC_BITS-1:0] ys [CORDIC_STEPS+1];
  logic signed [ZB-1:0] zs [CORDIC_STEPS+1];
  logic signed [ZB-1:0] z0;

  always_comb begin
    if (ANGLE_BITS <= 31) begin
      z0 = ZB'(signed'(angle)) <<< (31 - ANGLE_BITS);
    end else begin
      z0 = ZB'(signed'(angle) >>> (ANGLE_BITS - 31));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= z0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam int SH = (i < MAX_STEPS) ? i : MAX_STEPS - 1;
    localparam logic signed [ZB-1:0] AT = (i < MAX_STEPS) ? atan_entry(i) : '0;
    always_ff @(posedge clk) begin
      if (en) begin
        if (i >= MAX_STEPS) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> SH);
          ys[i+1] <= ys[i] + (xs[i] >>> SH);
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> SH);
          ys[i+1] <= ys[i] - (xs[i] >>> SH);
          zs[i+1] <= zs[i] + AT;
        end
      end
    end
  end

  assign cos_out = xs[CORDIC_STEPS];
  assign sin_out = ys[CORDIC_STEPS];

endmodule

// ----- sv/e2q_merge.sv -----
// ----------------------------------------------------------------------------
// e2q_merge
// forms the four triple product sums, rounds and saturates to q1.frac
// ----------------------------------------------------------------------------
module e2q_merge #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic en,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] cr,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] sr,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] cp,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] sp,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] cy,
  input  logic signed [e2q_pkg::VEC_BITS-1:0] sy,
  output logic signed [FRAC_BITS+1:0] quat_w,
  output logic signed [FRAC_BITS+1:0] quat_x,
  output logic signed [FRAC_BITS+1:0] quat_y,
  output logic signed [FRAC_BITS+1:0] quat_z
);
  import e2q_pkg::*;

  localparam int PB = 2 * VEC_BITS;
  localparam int SB = PB + 1;
  localparam int SH = 60 - FRAC_BITS;
  localparam int OB = FRAC_BITS + 2;

  logic signed [PB-1:0] p_crcp, p_srsp, p_srcp, p_crsp;
  logic signed [VEC_BITS-1:0] crcp, srsp, srcp, crsp, cy1, sy1, cy2, sy2;
  logic signed [PB-1:0] t [8];
  logic signed [SB-1:0] sum [4];
  logic signed [SB-1:0] rnd [4];
  logic signed [OB-1:0] sat [4];

  function automatic logic signed [VEC_BITS-1:0] r30(input logic signed [PB-1:0] p);
    logic signed [PB-1:0] q;
    begin
      q = (p + (PB'(1) <<< 29)) >>> 30;
      return q[VEC_BITS-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_crcp <= PB'(cr) * PB'(cp);
      p_srsp <= PB'(sr) * PB'(sp);
      p_srcp <= PB'(sr) * PB'(cp);
      p_crsp <= PB'(cr) * PB'(sp);
      cy1 <= cy;
      sy1 <= sy;
      crcp <= r30(p_crcp);
      srsp <= r30(p_srsp);
      srcp <= r30(p_srcp);
      crsp <= r30(p_crsp);
      cy2 <= cy1;
      sy2 <= sy1;
      t[0] <= PB'(crcp) * PB'(cy2);
      t[1] <= PB'(srsp) * PB'(sy2);
      t[2] <= PB'(srcp) * PB'(cy2);
      t[3] <= PB'(crsp) * PB'(sy2);
      t[4] <= PB'(crsp) * PB'(cy2);
      t[5] <= PB'(srcp) * PB'(sy2);
      t[6] <= PB'(crcp) * PB'(sy2);
      t[7] <= PB'(srsp) * PB'(cy2);
      sum[0] <= SB'(t[0]) + SB'(t[1]);
      sum[1] <= SB'(t[2]) - SB'(t[3]);
      sum[2] <= SB'(t[4]) + SB'(t[5]);
      sum[3] <= SB'(t[6]) - SB'(t[7]);
      for (int k = 0; k < 4; k++) begin
        sat[k] <= (rnd[k] > (SB'(1) <<< FRAC_BITS)) ? OB'(1) <<< FRAC_BITS :
                  (rnd[k] < -(SB'(1) <<< FRAC_BITS)) ? -(OB'(1) <<< FRAC_BITS) :
                  rnd[k][OB-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sum[k] + (SB'(1) <<< (SH - 1))) >>> SH;
    end
  end

  assign quat_w = sat[0];
  assign quat_x = sat[1];
  assign quat_y = sat[2];
  assign quat_z = sat[3];

endmodule
